// ----- rtl/core/sli_pkg.sv -----
// Shared constants and types for the sorted list block.
// No dependencies; imported by sli_cell and sorted_list_insert_delete.
package sli_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 2;
    localparam int IDX_W    = 4;
    localparam int ST_W     = 3;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
    localparam logic [ST_W-1:0] ST_RANGE     = 3'd4;

    // Broadcast to every cell: which list update commits this cycle.
    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctl_t;

endpackage

// ----- rtl/core/sli_cell.sv -----
// One position of the sorted list: entry register, occupancy bit, compares.
// Depends on sli_pkg.
module sli_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  sli_pkg::cell_ctl_t           ctl,
    input  logic signed [sli_pkg::DATA_W-1:0] value,
    input  logic signed [sli_pkg::DATA_W-1:0] left_entry,
    input  logic                         left_gt,
    input  logic                         left_occ,
    input  logic signed [sli_pkg::DATA_W-1:0] right_entry,
    input  logic                         right_occ,
    output logic signed [sli_pkg::DATA_W-1:0] entry,
    output logic                         occ,
    output logic                         gt,
    output logic                         eq
);
    import sli_pkg::*;

    logic signed [DATA_W-1:0] entry_reg;
    logic signed [DATA_W-1:0] entry_next;
    logic                     occ_reg;
    logic                     occ_next;
    logic                     ge;

    assign gt = occ_reg && (entry_reg > value);
    assign ge = occ_reg && (entry_reg >= value);
    assign eq = occ_reg && (entry_reg == value);

    always_comb
    begin
        entry_next = entry_reg;
        occ_next   = occ_reg;
        if (ctl.ins)
        begin
            occ_next = left_occ;
            if (left_gt)
            begin
                entry_next = left_entry;
            end
            else if (gt || (!occ_reg && left_occ))
            begin
                // first larger entry, or the first free slot
                entry_next = value;
            end
        end
        else if (ctl.del)
        begin
            occ_next = right_occ;
            if (ge)
            begin
                entry_next = right_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    assign entry = entry_reg;
    assign occ   = occ_reg;

endmodule

// ----- rtl/core/sorted_list_insert_delete.sv -----
// Sorted list of signed words held in a chain of compare-and-shift cells.
// An accepted word's result word is loaded into the output register in the next cycle.
// Throughput: one word per cycle while in_stall is low; all cells compare and shift in the same cycle.
// Reset (rst_n, async, low) empties the list and clears the output valid.
// Depends on sli_pkg and sli_cell.
module sorted_list_insert_delete (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [sli_pkg::CMD_W-1:0]         command,
    input  logic signed [sli_pkg::DATA_W-1:0] value,
    input  logic [sli_pkg::IDX_W-1:0]         index,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [sli_pkg::ST_W-1:0]          status,
    output logic [sli_pkg::CNT_W-1:0]         count,
    output logic signed [sli_pkg::DATA_W-1:0] read_value
);
    import sli_pkg::*;

    logic signed [DATA_W-1:0] cell_entry [CAPACITY];
    logic [CAPACITY-1:0]      cell_occ;
    logic [CAPACITY-1:0]      cell_gt;
    logic [CAPACITY-1:0]      cell_eq;
    logic [CAPACITY-1:0]      rd_hit;

    cell_ctl_t                ctl;
    logic                     accept;
    logic                     full;
    logic                     empty;
    logic                     found;
    logic                     in_range;
    logic signed [DATA_W-1:0] rd_mux;

    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [ST_W-1:0]          status_reg;
    logic [ST_W-1:0]          status_next;
    logic [CNT_W-1:0]         out_count_reg;
    logic signed [DATA_W-1:0] read_value_reg;
    logic signed [DATA_W-1:0] read_value_next;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign full     = cell_occ[CAPACITY-1];
    assign empty    = !cell_occ[0];
    assign found    = |cell_eq;
    assign in_range = (32'(index) < 32'(count_reg));

    assign ctl.ins = accept && (command == CMD_INSERT) && !full;
    assign ctl.del = accept && (command == CMD_DELETE) && found;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            sli_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .value       (value),
                .left_entry  (value),
                .left_gt     (1'b0),
                .left_occ    (1'b1),
                .right_entry (cell_entry[i+1]),
                .right_occ   (cell_occ[i+1]),
                .entry       (cell_entry[i]),
                .occ         (cell_occ[i]),
                .gt          (cell_gt[i]),
                .eq          (cell_eq[i])
            );
        end
        else if (i == CAPACITY - 1)
        begin : g_tail
            sli_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .value       (value),
                .left_entry  (cell_entry[i-1]),
                .left_gt     (cell_gt[i-1]),
                .left_occ    (cell_occ[i-1]),
                .right_entry (cell_entry[i]),
                .right_occ   (1'b0),
                .entry       (cell_entry[i]),
                .occ         (cell_occ[i]),
                .gt          (cell_gt[i]),
                .eq          (cell_eq[i])
            );
        end
        else
        begin : g_mid
            sli_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .value       (value),
                .left_entry  (cell_entry[i-1]),
                .left_gt     (cell_gt[i-1]),
                .left_occ    (cell_occ[i-1]),
                .right_entry (cell_entry[i+1]),
                .right_occ   (cell_occ[i+1]),
                .entry       (cell_entry[i]),
                .occ         (cell_occ[i]),
                .gt          (cell_gt[i]),
                .eq          (cell_eq[i])
            );
        end
        assign rd_hit[i] = (32'(index) == 32'(i));
    end

    // and-or select of the indexed cell
    always_comb
    begin
        rd_mux = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_mux = rd_mux | (cell_entry[i] & {DATA_W{rd_hit[i]}});
        end
    end

    always_comb
    begin
        status_next     = ST_OK;
        read_value_next = '0;
        count_next      = count_reg;
        case (command)
            CMD_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_DELETE:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!found)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_READ:
            begin
                if (in_range)
                begin
                    read_value_next = rd_mux;
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign out_valid_next = accept || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg     <= status_next;
            out_count_reg  <= count_next;
            read_value_reg <= read_value_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign count      = out_count_reg;
    assign read_value = read_value_reg;

`ifndef SYNTHESIS
    // occupancy must stay a contiguous run from the head cell
    a_occ_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (cell_occ[CAPACITY-1:1] & ~cell_occ[CAPACITY-2:0]) == '0)
        else $error("occupancy bits not contiguous");

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_occ) == 32'(count_reg))
        else $error("fill count disagrees with occupied cells");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_FULL) |-> (32'(out_count_reg) == CAPACITY))
        else $error("full status reported below capacity");

    a_single_update: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.ins && ctl.del))
        else $error("insert and delete committed together");
`endif

endmodule

// ----- dv/tb.sv -----
// Testbench for sorted_list_insert_delete: sends insert, delete, read and unused-code words
// and checks every reply against a behavioral copy of the sorted list.
// Depends on sli_pkg and the RTL of sorted_list_insert_delete.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sli_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int N_WORDS     = 1950;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] val;
        logic [IDX_W-1:0]         idx;
        bit                       steady;  // no gap after this word
    } list_cmd_t;

    typedef struct {
        logic [ST_W-1:0]          status;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] rd;
    } list_reply_t;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         index;
    logic                     out_valid;
    logic                     out_stall;
    logic [ST_W-1:0]          status;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] read_value;

    list_cmd_t   cmds_to_send[$];
    list_reply_t replies_due[$];
    list_cmd_t   next_cmd;
    list_reply_t due;

    // behavioral list, kept in step with accepted words
    logic signed [DATA_W-1:0] held[CAPACITY];
    int held_cnt = 0;

    // list contents as seen while planning stimulus
    logic signed [DATA_W-1:0] gen_held[$];

    bit word_sent = 1'b0;
    bit word_recv = 1'b0;
    bit rx_hold   = 1'b0;
    int gap_left  = 0;
    int rx_wait   = 0;
    int rx_draw;
    int words_sent   = 0;
    int replies_seen = 0;
    int err_cnt      = 0;
    int cycles       = 0;

    sorted_list_insert_delete uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .command    (command),
        .value      (value),
        .index      (index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .count      (count),
        .read_value (read_value)
    );

    function automatic list_reply_t apply_to_list(logic [CMD_W-1:0] c,
                                                  logic signed [DATA_W-1:0] v,
                                                  logic [IDX_W-1:0] ix);
        list_reply_t r;
        int pos;
        r.status = ST_OK;
        r.rd     = '0;
        pos      = 0;
        if (c == CMD_INSERT) begin
            if (held_cnt >= CAPACITY)
                r.status = ST_FULL;
            else
            begin
                // new entry goes in front of the first larger one
                while (pos < held_cnt && held[pos] <= v)
                    pos++;
                for (int k = held_cnt; k > pos; k--)
                    held[k] = held[k-1];
                held[pos] = v;
                held_cnt++;
            end
        end
        else if (c == CMD_DELETE) begin
            if (held_cnt == 0)
                r.status = ST_EMPTY;
            else
            begin
                while (pos < held_cnt && held[pos] != v)
                    pos++;
                if (pos >= held_cnt)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    for (int k = pos; k + 1 < held_cnt; k++)
                        held[k] = held[k+1];
                    held_cnt--;
                end
            end
        end
        else if (c == CMD_READ) begin
            if (ix < held_cnt)
                r.rd = held[ix];
            else
                r.status = ST_RANGE;
        end
        r.count = held_cnt[CNT_W-1:0];
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $signed($urandom_range(0, 8)) - 4;  // crowded, many duplicates
            4:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'sh7fffffff;
                    1: return 32'sh80000000;
                    2: return 32'sh7ffffffe;
                    default: return 32'sh80000001;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    task automatic add_word(input logic [CMD_W-1:0] c, input logic signed [DATA_W-1:0] v,
                            input logic [IDX_W-1:0] ix);
        list_cmd_t w;
        int k;
        w.cmd    = c;
        w.val    = v;
        w.idx    = ix;
        w.steady = (cmds_to_send.size() % 600) > 450;
        cmds_to_send.push_back(w);
        if (c == CMD_INSERT && gen_held.size() < CAPACITY)
            gen_held.push_back(v);
        else if (c == CMD_DELETE) begin
            k = 0;
            while (k < gen_held.size() && gen_held[k] != v)
                k++;
            if (k < gen_held.size())
                gen_held.delete(k);
        end
    endtask

    // Runs of 20..60 words that lean toward growing, shrinking or neither,
    // so the list swings between empty and full.
    task automatic plan_random();
        int mode;
        int left;
        int roll;
        int n;
        mode = 0;
        left = 0;
        n    = cmds_to_send.size();
        while (n < N_WORDS) begin
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(20, 60);
            end
            left--;
            roll = $urandom_range(0, 99);
            if (roll < 2)
                add_word(CMD_UNUSED, $urandom(), IDX_W'($urandom_range(0, 15)));
            else
            begin
                n++;
                if (roll < 20) begin
                    if (gen_held.size() > 0 && roll < 15)
                        add_word(CMD_READ, pick_value(),
                                 IDX_W'($urandom_range(0, gen_held.size() - 1)));
                    else
                        add_word(CMD_READ, pick_value(), IDX_W'($urandom_range(0, 15)));
                end
                else if ((mode == 0 && roll < 85) || (mode == 1 && roll < 30)
                         || (mode == 2 && roll < 60))
                    add_word(CMD_INSERT, pick_value(), IDX_W'($urandom_range(0, 15)));
                else if (gen_held.size() > 0 && $urandom_range(0, 5) != 0)
                    add_word(CMD_DELETE, gen_held[$urandom_range(0, gen_held.size() - 1)],
                             IDX_W'($urandom_range(0, 15)));
                else
                    add_word(CMD_DELETE, pick_value(), IDX_W'($urandom_range(0, 15)));
            end
        end
    endtask

    task automatic flag_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%s", msg);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sender
    always @(negedge clk) begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || word_sent) begin
            if (gap_left > 0) begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (cmds_to_send.size() > 0) begin
                next_cmd = cmds_to_send.pop_front();
                command  <= next_cmd.cmd;
                value    <= next_cmd.val;
                index    <= next_cmd.idx;
                in_valid <= 1'b1;
                gap_left <= next_cmd.steady ? 0 : $urandom_range(0, 3);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk) begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (rx_hold)
            out_stall <= 1'b1;
        else if (rx_wait > 0) begin
            out_stall <= 1'b1;
            rx_wait   <= rx_wait - 1;
        end
        else if (word_recv) begin
            rx_draw   = ((replies_seen % 700) > 550) ? 0 : $urandom_range(0, 3);
            out_stall <= (rx_draw > 0);
            rx_wait   <= (rx_draw > 0) ? rx_draw - 1 : 0;
        end
        else
            out_stall <= 1'b0;
    end

    // Long receiver hold-off: the output register fills and in_stall must rise.
    initial
    begin
        while (replies_seen < 300)
            @(negedge clk);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // monitor: replies are checked before the word accepted on the same edge is predicted
    always @(posedge clk) begin
        if (!rst_n) begin
            word_sent <= 1'b0;
            word_recv <= 1'b0;
        end
        else
        begin
            word_sent <= in_valid && !in_stall;
            word_recv <= out_valid && !out_stall;
            if (out_valid && !out_stall) begin
                if (replies_due.size() == 0)
                    flag_error($sformatf("unexpected reply: status %0d count %0d value %0d",
                                         status, count, read_value));
                else
                begin
                    due = replies_due.pop_front();
                    if (status !== due.status || count !== due.count || read_value !== due.rd)
                        flag_error($sformatf({"reply %0d: expected status %0d count %0d ",
                                              "value %0d, got status %0d count %0d value %0d"},
                                             replies_seen, due.status, due.count, due.rd,
                                             status, count, read_value));
                end
                replies_seen <= replies_seen + 1;
            end
            if (in_valid && !in_stall) begin
                replies_due.push_back(apply_to_list(command, value, index));
                words_sent <= words_sent + 1;
            end
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int total;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        command   = CMD_INSERT;
        value     = '0;
        index     = '0;
        out_stall = 1'b0;

        add_word(CMD_READ, '0, 4'd0);                 // read of an empty list
        add_word(CMD_DELETE, 32'sd7, 4'd0);           // delete on empty
        add_word(CMD_UNUSED, -1, 4'd15);              // unused code, no effect
        add_word(CMD_INSERT, 32'sh7fffffff, 4'd0);
        add_word(CMD_INSERT, 32'sh80000000, 4'd0);
        add_word(CMD_INSERT, 32'sd0, 4'd0);
        add_word(CMD_INSERT, -1, 4'd0);
        add_word(CMD_INSERT, 32'sd0, 4'd0);           // duplicate
        add_word(CMD_READ, '0, 4'd0);
        add_word(CMD_READ, '0, 4'd15);                // index past the count
        add_word(CMD_DELETE, 32'sd5, 4'd0);           // absent value
        add_word(CMD_DELETE, 32'sd0, 4'd0);           // one of the duplicates
        for (int k = 0; k < 12; k++)
            add_word(CMD_INSERT, pick_value(), 4'd0);
        add_word(CMD_INSERT, 32'sd1, 4'd0);           // full, dropped
        add_word(CMD_READ, '0, 4'd15);                // last slot of a full list
        plan_random();
        total = cmds_to_send.size();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (words_sent < total || replies_due.size() > 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (replies_due.size() != 0)
            flag_error($sformatf("%0d replies never arrived", replies_due.size()));
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
